// ----- hw/rtl/tfep_pkg.sv -----
// shared types, codes and target selection for the elevator planner
`default_nettype none
package tfep_pkg;

    // field widths
    localparam int unsigned OP_W     = 4;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned F2_W     = 11;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned FLOOR_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 24;

    // quotient steps for floor mapping (floors 1..3 need quotient 0..2)
    localparam logic [1:0] DIV_LAST_STEP = 2'd2;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_NONE          = 4'd0,
        OP_CALL1         = 4'd1,
        OP_CALL2         = 4'd2,
        OP_CALL3         = 4'd3,
        OP_ARRIVED       = 4'd4,
        OP_LEFT          = 4'd5,
        OP_DOORS_CLOSED  = 4'd6,
        OP_DOORS_OPENING = 4'd7,
        OP_STOP_PRESSED  = 4'd8,
        OP_STOP_RELEASED = 4'd9
    } op_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR1_POS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR2_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR3_POS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_F2_UPPER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_F2_LOWER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS  = 3'd5;

    // motor stop actions
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_MOTOR   = 2'd1;
    localparam logic [1:0] STOP_RELEASE = 2'd2;

    // floor codes
    localparam logic [FLOOR_W-1:0] FLOOR_NONE = 2'd0;
    localparam logic [FLOOR_W-1:0] FLOOR_1    = 2'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_2    = 2'd2;
    localparam logic [FLOOR_W-1:0] FLOOR_3    = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EVENT,
        ST_DWELL,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic do_event;
        logic do_dwell;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // outcome of a target choice
    typedef struct packed {
        logic                move;
        logic [FLOOR_W-1:0]  floor;
    } choice_t;

    // priority rules: floor 2 when not too close, then floor 3, then floor 1
    function automatic choice_t choose_target(
        input logic [2:0]         calls,
        input logic               up,
        input logic [FLOOR_W-1:0] cur,
        input logic               above_upper,
        input logic               below_lower
    );
        choice_t ch;
        ch.move  = 1'b0;
        ch.floor = cur;
        if (calls[1] && ((!up && above_upper) || (up && below_lower))) begin
            ch.move  = 1'b1;
            ch.floor = FLOOR_2;
        end else if (calls[2] && ((up && cur != FLOOR_2) || (!calls[0] && !calls[1]))) begin
            ch.move  = 1'b1;
            ch.floor = FLOOR_3;
        end else if (calls[0] && ((!up && cur != FLOOR_2) || (!calls[1] && !calls[2]))) begin
            ch.move  = 1'b1;
            ch.floor = FLOOR_1;
        end else if (calls == 3'b000) begin
            ch.floor = FLOOR_NONE;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tfep_ctrl.sv -----
// controller state machine sequencing one poll item through the datapath
`default_nettype none
module tfep_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tfep_pkg::dp_status_t status,
    output tfep_pkg::ctrl_cmd_t      cmd
);
    import tfep_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = 2'd0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == DIV_LAST_STEP) begin
                    state_next = ST_EVENT;
                end
            end
            ST_EVENT: begin
                cmd.do_event = 1'b1;
                state_next   = ST_DWELL;
            end
            ST_DWELL: begin
                cmd.do_dwell = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tfep_datapath.sv -----
// planner state, configuration registers, floor mapping and result register
`default_nettype none
module tfep_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [tfep_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [tfep_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tfep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tfep_pkg::POS_W-1:0]    cfg_data,
    input  wire tfep_pkg::ctrl_cmd_t           cmd,
    output tfep_pkg::dp_status_t               status
);
    import tfep_pkg::*;

    // configuration
    logic [POS_W-1:0]  f1_pos_reg, f1_pos_next;
    logic [F2_W-1:0]   f2_pos_reg, f2_pos_next;
    logic [POS_W-1:0]  f3_pos_reg, f3_pos_next;
    logic [POS_W-1:0]  upper_reg, upper_next;
    logic [POS_W-1:0]  lower_reg, lower_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;

    // item in flight
    logic [OP_W-1:0]   op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              neg_reg, neg_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [1:0]        quot_reg, quot_next;

    // planner state
    logic [2:0]         calls_reg, calls_next;
    logic [FLOOR_W-1:0] target_reg, target_next;
    logic               up_reg, up_next;
    logic               dwell_reg, dwell_next;
    logic [TICK_W-1:0]  count_reg, count_next;
    logic [FLOOR_W-1:0] floor_reg, floor_next;
    logic               shut_reg, shut_next;

    // per-item result parts
    logic               move_reg, move_next;
    logic [POS_W-1:0]   cmd_pos_reg, cmd_pos_next;
    logic [1:0]         stop_reg, stop_next;

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [POS_W:0]     num_in;
    logic [POS_W:0]     mag_in;
    logic               rem_ge;
    logic [FLOOR_W-1:0] mapped;
    logic               above_upper;
    logic               below_lower;
    logic [2:0]         calls_set;
    logic [2:0]         calls_dwell;
    choice_t            ch_event;
    choice_t            ch_dwell;

    function automatic logic [POS_W-1:0] floor_pos(
        input logic [FLOOR_W-1:0] fl,
        input logic [POS_W-1:0]   p1,
        input logic [F2_W-1:0]    p2,
        input logic [POS_W-1:0]   p3
    );
        logic [POS_W-1:0] r;
        case (fl)
            FLOOR_1: r = p1;
            FLOOR_2: r = {1'b0, p2};
            FLOOR_3: r = p3;
            default: r = '0;
        endcase
        return r;
    endfunction

    // magnitude of position plus one for the floor mapping
    assign num_in = {s_tdata[POS_W+OP_W-1], s_tdata[POS_W+OP_W-1:OP_W]} + 13'd1;
    assign mag_in = num_in[POS_W] ? (~num_in + 13'd1) : num_in;

    // one subtract and compare per step
    assign rem_ge = rem_reg >= {1'b0, f2_pos_reg};

    // truncated quotient must be 0..2, and only 0 for a negative numerator
    always_comb begin
        if (quot_reg == 2'd3 || (neg_reg && quot_reg != 2'd0)) begin
            mapped = FLOOR_NONE;
        end else begin
            mapped = quot_reg + 2'd1;
        end
    end

    // floor 2 proximity checks
    assign above_upper = $signed(pos_reg) > $signed(upper_reg);
    assign below_lower = $signed(pos_reg) < $signed(lower_reg);

    // call set from a call event, calls after the dwell clears the present floor
    assign calls_set   = calls_reg | (3'b001 << (op_reg[1:0] - 2'd1));
    assign calls_dwell = (floor_reg != FLOOR_NONE) ?
                         (calls_reg & ~(3'b001 << (floor_reg - 2'd1))) : calls_reg;

    assign ch_event = choose_target(calls_set, up_reg, target_reg, above_upper, below_lower);
    assign ch_dwell = choose_target(calls_dwell, up_reg, FLOOR_NONE, above_upper,
                                    below_lower);

    // next-state logic
    always_comb begin
        f1_pos_next   = f1_pos_reg;
        f2_pos_next   = f2_pos_reg;
        f3_pos_next   = f3_pos_reg;
        upper_next    = upper_reg;
        lower_next    = lower_reg;
        ticks_next    = ticks_reg;
        op_next       = op_reg;
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        calls_next    = calls_reg;
        target_next   = target_reg;
        up_next       = up_reg;
        dwell_next    = dwell_reg;
        count_next    = count_reg;
        floor_next    = floor_reg;
        shut_next     = shut_reg;
        move_next     = move_reg;
        cmd_pos_next  = cmd_pos_reg;
        stop_next     = stop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FLOOR1_POS:  f1_pos_next = cfg_data;
                REG_FLOOR2_POS:  f2_pos_next = cfg_data[F2_W-1:0];
                REG_FLOOR3_POS:  f3_pos_next = cfg_data;
                REG_F2_UPPER:    upper_next  = cfg_data;
                REG_F2_LOWER:    lower_next  = cfg_data;
                REG_DWELL_TICKS: ticks_next  = cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end

        // input transfer
        if (cmd.load) begin
            op_next      = s_tdata[OP_W-1:0];
            pos_next     = s_tdata[POS_W+OP_W-1:OP_W];
            neg_next     = num_in[POS_W];
            rem_next     = mag_in[POS_W-1:0];
            quot_next    = 2'd0;
            move_next    = 1'b0;
            cmd_pos_next = '0;
            stop_next    = STOP_NONE;
        end

        // floor mapping step
        if (cmd.div_step && rem_ge) begin
            rem_next  = rem_reg - {1'b0, f2_pos_reg};
            quot_next = quot_reg + 2'd1;
        end

        // apply the event
        if (cmd.do_event) begin
            case (op_t'(op_reg))
                OP_CALL1, OP_CALL2, OP_CALL3: begin
                    calls_next = calls_set;
                    if (!dwell_reg) begin
                        target_next = ch_event.floor;
                        if (ch_event.move) begin
                            move_next    = 1'b1;
                            cmd_pos_next = floor_pos(ch_event.floor, f1_pos_reg,
                                                     f2_pos_reg, f3_pos_reg);
                        end
                    end
                end
                OP_ARRIVED: begin
                    floor_next = mapped;
                    if (mapped != FLOOR_NONE && mapped == target_reg) begin
                        calls_next = calls_reg & ~(3'b001 << (mapped - 2'd1));
                        dwell_next = 1'b1;
                        count_next = '0;
                        if (mapped == FLOOR_3) begin
                            up_next = 1'b0;
                        end else if (mapped == FLOOR_1) begin
                            up_next = 1'b1;
                        end
                    end
                end
                OP_LEFT:          floor_next = FLOOR_NONE;
                OP_DOORS_CLOSED:  shut_next  = 1'b1;
                OP_DOORS_OPENING: shut_next  = 1'b0;
                OP_STOP_PRESSED:  stop_next  = STOP_MOTOR;
                OP_STOP_RELEASED: stop_next  = STOP_RELEASE;
                default: ;
            endcase
        end

        // dwell at the floor, then depart once doors are closed
        if (cmd.do_dwell && dwell_reg) begin
            if (count_reg < ticks_reg) begin
                count_next = count_reg + 8'd1;
            end else begin
                calls_next = calls_dwell;
                if (shut_reg) begin
                    target_next = ch_dwell.floor;
                    if (ch_dwell.move) begin
                        move_next    = 1'b1;
                        cmd_pos_next = floor_pos(ch_dwell.floor, f1_pos_reg,
                                                 f2_pos_reg, f3_pos_reg);
                    end
                    if (ch_dwell.floor != FLOOR_NONE) begin
                        if (ch_dwell.floor < floor_reg) begin
                            dwell_next = 1'b0;
                            up_next    = 1'b0;
                        end else if (ch_dwell.floor > floor_reg) begin
                            dwell_next = 1'b0;
                            up_next    = 1'b1;
                        end
                    end
                end
            end
        end

        // result register
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, up_reg, dwell_reg, stop_reg, cmd_pos_reg, move_reg,
                             target_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_pos_reg   <= 12'd0;
            f2_pos_reg   <= 11'd400;
            f3_pos_reg   <= 12'd800;
            upper_reg    <= 12'd500;
            lower_reg    <= 12'd300;
            ticks_reg    <= 8'd40;
            calls_reg    <= 3'b000;
            target_reg   <= FLOOR_NONE;
            up_reg       <= 1'b1;
            dwell_reg    <= 1'b1;
            count_reg    <= '0;
            floor_reg    <= FLOOR_1;
            shut_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            f1_pos_reg   <= f1_pos_next;
            f2_pos_reg   <= f2_pos_next;
            f3_pos_reg   <= f3_pos_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
            ticks_reg    <= ticks_next;
            calls_reg    <= calls_next;
            target_reg   <= target_next;
            up_reg       <= up_next;
            dwell_reg    <= dwell_next;
            count_reg    <= count_next;
            floor_reg    <= floor_next;
            shut_reg     <= shut_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        move_reg    <= move_next;
        cmd_pos_reg <= cmd_pos_next;
        stop_reg    <= stop_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

// ----- hw/rtl/three_floor_elevator_planner_top.sv -----
// top level of the three-floor elevator planner
//
// One input transfer per poll period carries an event code and the measured
// car position; each one yields exactly one result transfer with the target
// floor, an optional position command, the motor stop action, the dwell flag
// and the travel direction.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); the user
// must write it only while no item is in flight, the block does not enforce it.
// From input transfer to result valid an item passes 3 steps of the
// compare-and-subtract unit that maps position to a floor, event apply,
// dwell update and result load. The controller walks one item at a time and
// takes the next item only once it is back in its idle state.
// The result sits in an output register, so the next input is taken while a
// result still waits; if the receiver stalls longer, the controller holds the
// finished item until the output register frees up.
// Synchronous active-low reset restores the register defaults, clears all
// calls, sets direction up, dwell on, present floor 1, doors open, and drops
// m_tvalid.
`default_nettype none
module three_floor_elevator_planner_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // operation [3:0], car_position [15:4]
    input  wire logic [tfep_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // target_floor [1:0], move_command [2], commanded_position [14:3],
    // motor_stop_action [16:15], waiting_at_floor [17], going_up [18]
    output logic      [tfep_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tfep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tfep_pkg::POS_W-1:0]     cfg_data
);
    import tfep_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    tfep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // planner state and arithmetic
    tfep_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/tfep_checker.sv -----
// port-level checks for the elevator planner, bound to the top level
`default_nettype none
module tfep_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic [tfep_pkg::S_DATA_W-1:0]  s_tdata,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [tfep_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);
    import tfep_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no position command means a zero position field
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[14:3] == '0))
        else $error("commanded position without move command");

    // stop action is never the unused code
    a_stop_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16:15] == STOP_NONE || m_tdata[16:15] == STOP_MOTOR ||
                      m_tdata[16:15] == STOP_RELEASE))
        else $error("bad motor stop action");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind three_floor_elevator_planner_top tfep_checker u_tfep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

// ----- dv/elevator_plan_checker.sv -----
// result checker for the elevator planner: predicts every result and compares it
module elevator_plan_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tfep_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tfep_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [tfep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfep_pkg::POS_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending_results
);
    import tfep_pkg::*;

    // one result transfer, field by field
    typedef struct {
        logic [FLOOR_W-1:0] target;
        logic               move;
        logic [POS_W-1:0]   cmd_pos;
        logic [1:0]         stop;
        logic               waiting;
        logic               up;
    } plan_t;

    // outcome of a destination pick
    typedef struct {
        logic               move;
        logic [FLOOR_W-1:0] floor;
        logic [POS_W-1:0]   pos;
    } destination_t;

    // register copies
    logic signed [POS_W-1:0] f1_pos;
    logic [F2_W-1:0]         f2_pos;
    logic signed [POS_W-1:0] f3_pos;
    logic signed [POS_W-1:0] f2_upper;
    logic signed [POS_W-1:0] f2_lower;
    logic [TICK_W-1:0]       dwell_limit;

    // planner state copies
    logic [2:0]              pending_calls;
    logic [FLOOR_W-1:0]      dest_floor;
    logic                    moving_up;
    logic                    parked;
    logic [TICK_W-1:0]       park_ticks;
    logic [FLOOR_W-1:0]      car_floor;
    logic                    door_shut_flag;

    plan_t expected_plans[$];

    // floor 2 unless too close, then floor 3, then floor 1
    function automatic destination_t pick_destination(input logic [FLOOR_W-1:0] cur,
                                                      input logic signed [POS_W-1:0] pos);
        destination_t d;
        logic c1, c2, c3;
        c1 = pending_calls[0];
        c2 = pending_calls[1];
        c3 = pending_calls[2];
        d.move  = 1'b0;
        d.floor = cur;
        d.pos   = '0;
        if (c2 && ((!moving_up && pos > f2_upper) || (moving_up && pos < f2_lower))) begin
            d.move  = 1'b1;
            d.floor = FLOOR_2;
            d.pos   = {1'b0, f2_pos};
        end else if (c3 && ((moving_up && cur != FLOOR_2) || (!c1 && !c2))) begin
            d.move  = 1'b1;
            d.floor = FLOOR_3;
            d.pos   = f3_pos;
        end else if (c1 && ((!moving_up && cur != FLOOR_2) || (!c2 && !c3))) begin
            d.move  = 1'b1;
            d.floor = FLOOR_1;
            d.pos   = f1_pos;
        end else if (!c1 && !c2 && !c3) begin
            d.floor = FLOOR_NONE;
        end
        return d;
    endfunction

    // position to floor number, quotient truncated toward zero
    function automatic logic [FLOOR_W-1:0] floor_of(input logic signed [POS_W-1:0] pos);
        int divisor;
        int level;
        divisor = int'(f2_pos);
        if (divisor == 0)
            return FLOOR_NONE;
        level = (int'(pos) + 1) / divisor + 1;
        if (level < int'(FLOOR_1) || level > int'(FLOOR_3))
            return FLOOR_NONE;
        return level[FLOOR_W-1:0];
    endfunction

    // one poll period: event first, then the dwell update
    task automatic advance_planner(input logic [OP_W-1:0] op,
                                   input logic signed [POS_W-1:0] pos,
                                   output plan_t p);
        destination_t d;
        logic [1:0]       stop;
        logic             move;
        logic [POS_W-1:0] move_pos;
        stop     = STOP_NONE;
        move     = 1'b0;
        move_pos = '0;
        case (op)
            OP_CALL1, OP_CALL2, OP_CALL3: begin
                pending_calls[op - OP_CALL1] = 1'b1;
                if (!parked) begin
                    d = pick_destination(dest_floor, pos);
                    dest_floor = d.floor;
                    if (d.move) begin
                        move     = 1'b1;
                        move_pos = d.pos;
                    end
                end
            end
            OP_ARRIVED: begin
                car_floor = floor_of(pos);
                if (car_floor != FLOOR_NONE && car_floor == dest_floor) begin
                    pending_calls[car_floor - FLOOR_1] = 1'b0;
                    parked     = 1'b1;
                    park_ticks = '0;
                    if (car_floor == FLOOR_3)
                        moving_up = 1'b0;
                    else if (car_floor == FLOOR_1)
                        moving_up = 1'b1;
                end
            end
            OP_LEFT:          car_floor = FLOOR_NONE;
            OP_DOORS_CLOSED:  door_shut_flag = 1'b1;
            OP_DOORS_OPENING: door_shut_flag = 1'b0;
            OP_STOP_PRESSED:  stop = STOP_MOTOR;
            OP_STOP_RELEASED: stop = STOP_RELEASE;
            default: ;
        endcase

        // dwell at the floor, then depart once the doors are closed
        if (parked) begin
            if (park_ticks < dwell_limit) begin
                park_ticks = park_ticks + 1'b1;
            end else begin
                if (car_floor != FLOOR_NONE)
                    pending_calls[car_floor - FLOOR_1] = 1'b0;
                if (door_shut_flag) begin
                    d = pick_destination(FLOOR_NONE, pos);
                    dest_floor = d.floor;
                    if (d.move) begin
                        move     = 1'b1;
                        move_pos = d.pos;
                    end
                    if (dest_floor != FLOOR_NONE) begin
                        if (dest_floor < car_floor) begin
                            parked    = 1'b0;
                            moving_up = 1'b0;
                        end else if (dest_floor > car_floor) begin
                            parked    = 1'b0;
                            moving_up = 1'b1;
                        end
                    end
                end
            end
        end

        p.target  = dest_floor;
        p.move    = move;
        p.cmd_pos = move_pos;
        p.stop    = stop;
        p.waiting = parked;
        p.up      = moving_up;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // watch config writes and both channels at the rising edge
    always @(posedge aclk) begin
        plan_t want;
        plan_t got;
        if (!aresetn) begin
            f1_pos         = '0;
            f2_pos         = 11'd400;
            f3_pos         = 12'sd800;
            f2_upper       = 12'sd500;
            f2_lower       = 12'sd300;
            dwell_limit    = 8'd40;
            pending_calls  = '0;
            dest_floor     = FLOOR_NONE;
            moving_up      = 1'b1;
            parked         = 1'b1;
            park_ticks     = '0;
            car_floor      = FLOOR_1;
            door_shut_flag = 1'b0;
            fail_count     = 0;
            expected_plans.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FLOOR1_POS:  f1_pos      = cfg_data;
                    REG_FLOOR2_POS:  f2_pos      = cfg_data[F2_W-1:0];
                    REG_FLOOR3_POS:  f3_pos      = cfg_data;
                    REG_F2_UPPER:    f2_upper    = cfg_data;
                    REG_F2_LOWER:    f2_lower    = cfg_data;
                    REG_DWELL_TICKS: dwell_limit = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            // input transfer: predict its result
            if (s_tvalid && s_tready) begin
                advance_planner(s_tdata[3:0], s_tdata[15:4], want);
                expected_plans.push_back(want);
            end

            // result transfer: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.target  = m_tdata[1:0];
                got.move    = m_tdata[2];
                got.cmd_pos = m_tdata[14:3];
                got.stop    = m_tdata[16:15];
                got.waiting = m_tdata[17];
                got.up      = m_tdata[18];
                if (expected_plans.size() == 0) begin
                    $error("result transfer with no result expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_plans.pop_front();
                    check_field("target_floor", int'(want.target), int'(got.target));
                    check_field("move_command", int'(want.move), int'(got.move));
                    check_field("commanded_position", int'($signed(want.cmd_pos)),
                                int'($signed(got.cmd_pos)));
                    check_field("motor_stop_action", int'(want.stop), int'(got.stop));
                    check_field("waiting_at_floor", int'(want.waiting), int'(got.waiting));
                    check_field("going_up", int'(want.up), int'(got.up));
                end
            end
        end
        pending_results = expected_plans.size();
    end

endmodule

// ----- dv/three_floor_elevator_planner_top_tb.sv -----
// testbench top for the elevator planner: clock, reset, stimulus and verdict
module three_floor_elevator_planner_top_tb;
    import tfep_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASE_COUNT      = 9;
    localparam int ITEMS_PER_PHASE  = 135;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 20;
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_STOP_RELEASED + 1'b1;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    logic                 aclk;
    logic                 aresetn;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_data;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int items_sent = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 63;
    int cur_f2 = 400;

    three_floor_elevator_planner_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    elevator_plan_checker u_plan_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("[three_floor_elevator_planner_top] ERROR");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the block
    initial begin
        int  hold_left;
        bit  long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        m_tready       = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one poll transfer; returns at the falling edge after the transfer
    task automatic send_poll(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {pos, op};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // mostly calls, door events and arrivals aimed at a floor band
    task automatic send_random_poll();
        int               pick;
        int               level;
        int               offset;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(99);
        pos  = 12'($urandom_range(4095));
        if (pick < 18) begin
            op = OP_NONE;
        end else if (pick < 40) begin
            op = 4'(OP_CALL1 + $urandom_range(2));
            if ($urandom_range(1) == 1)
                pos = 12'($urandom_range(3 * cur_f2));
        end else if (pick < 62) begin
            op = OP_ARRIVED;
            if ($urandom_range(4) != 0) begin
                level  = $urandom_range(2);
                offset = (cur_f2 > 0) ? $urandom_range(cur_f2 - 1) : 0;
                pos    = 12'(level * cur_f2 + offset - 1);
            end
        end else if (pick < 72) begin
            op = OP_DOORS_CLOSED;
        end else if (pick < 77) begin
            op = OP_DOORS_OPENING;
        end else if (pick < 82) begin
            op = OP_LEFT;
        end else if (pick < 86) begin
            op = OP_STOP_PRESSED;
        end else if (pick < 90) begin
            op = OP_STOP_RELEASED;
        end else if (pick < 93) begin
            op = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        end else begin
            op = OP_NONE;
        end
        send_poll(op, pos);
    endtask

    // block is idle once every predicted result has come back
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input logic [POS_W-1:0] f1, input logic [F2_W-1:0] f2,
                              input logic [POS_W-1:0] f3, input logic [POS_W-1:0] upper,
                              input logic [POS_W-1:0] lower, input logic [TICK_W-1:0] dwell);
        write_reg(REG_FLOOR1_POS, f1);
        write_reg(REG_FLOOR2_POS, {1'b0, f2});
        write_reg(REG_FLOOR3_POS, f3);
        write_reg(REG_F2_UPPER, upper);
        write_reg(REG_F2_LOWER, lower);
        write_reg(REG_DWELL_TICKS, {4'b0, dwell});
        cur_f2 = int'(f2);
    endtask

    initial begin
        int phase;
        int i;
        int f2;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // directed: short dwell, every event, position extremes and band edges
        set_config(12'sd0, 11'd400, 12'sd800, 12'sd500, 12'sd300, 8'd2);
        send_poll(OP_NONE, 12'sd0);
        send_poll(OP_CALL3, 12'sd0);
        send_poll(OP_DOORS_CLOSED, 12'sd0);
        send_poll(OP_CALL2, 12'sd250);
        send_poll(OP_CALL1, 12'sh7FF);
        send_poll(OP_ARRIVED, 12'sh800);
        send_poll(OP_ARRIVED, 12'sd399);
        send_poll(OP_STOP_PRESSED, 12'sd0);
        send_poll(OP_STOP_RELEASED, 12'sd0);
        send_poll(OP_NONE, 12'sh800);
        send_poll(OP_LEFT, 12'sd0);
        send_poll(OP_ARRIVED, 12'sd800);
        send_poll(OP_DOORS_OPENING, 12'sd0);
        send_poll(OP_FIRST_UNUSED, 12'sd0);
        send_poll(OP_LAST_UNUSED, 12'sh7FF);
        send_poll(OP_DOORS_CLOSED, 12'sd0);
        send_poll(OP_CALL2, 12'sd600);
        send_poll(OP_ARRIVED, 12'sh7FF);
        send_poll(OP_ARRIVED, 12'sd500);
        send_poll(OP_CALL3, 12'sh800);
        send_poll(OP_NONE, 12'sd0);
        send_poll(OP_NONE, 12'sd0);
        // truncation toward zero keeps small negatives on floor 1
        send_poll(OP_ARRIVED, -12'sd1);
        send_poll(OP_ARRIVED, -12'sd2);

        // random phases: extremes first, then ordinary floor layouts
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase)
                0: set_config(12'sh800, 11'd2047, 12'sh7FF, 12'sh800, 12'sh7FF, 8'd1);
                // zero divisor and zero dwell
                1: set_config(12'sh7FF, 11'd0, 12'sh800, 12'sh7FF, 12'sh800, 8'd0);
                2: set_config(12'sh000, 11'd1, 12'sh001, 12'sh000, 12'sh002, 8'd255);
                default: begin
                    f2 = $urandom_range(700, 50);
                    set_config(12'($urandom_range(40)), 11'(f2),
                               12'(2 * f2 + $urandom_range(40)),
                               12'(f2 + $urandom_range(200)),
                               12'(f2 - $urandom_range(200)),
                               8'($urandom_range(6)));
                end
            endcase
            if (phase < 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 63;
            end else if (phase < 6) begin
                send_idle_pct = 63;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_poll();
        end

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("[three_floor_elevator_planner_top] OK");
        else
            $display("[three_floor_elevator_planner_top] ERROR");
        $finish;
    end

endmodule
